// ===== rtl/si_pkg.sv =====
// ----------------------------------------------------------------------------
// si_pkg: shared types and widths for segment intersection
// Coordinate format, derived arithmetic widths, status codes and beat types.
// ----------------------------------------------------------------------------
package si_pkg;

  localparam int CW = 16;          // coordinate width
  localparam int DW = CW + 1;      // endpoint difference
  localparam int PW = 2 * DW;      // difference product
  localparam int NW = PW + 1;      // denominator and numerators
  localparam int MW = DW + NW;     // direction times numerator
  localparam int VW = MW + 2;      // start plus quotient, before saturation
  localparam int DL = MW + 1;      // divider stages, sign split included

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    ST_PARALLEL = 2'd0,
    ST_HIT      = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_e;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t other_start_x;
    coord_t other_start_y;
    coord_t other_end_x;
    coord_t other_end_y;
  } seg_pair_t;

  typedef struct packed {
    status_e status;
    coord_t  meet_x;
    coord_t  meet_y;
    logic    clipped;
  } meet_t;

  typedef struct packed {
    logic signed [NW-1:0] den;
    logic signed [NW-1:0] numa;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    coord_t               sx;
    coord_t               sy;
    logic                 on_seg;
  } front_t;

endpackage

// ===== rtl/si_in_if.sv =====
// ----------------------------------------------------------------------------
// si_in_if: segment pair channel
// Valid/ready channel carrying one pair of segments per beat.
// ----------------------------------------------------------------------------
interface si_in_if;
  logic              valid;
  logic              ready;
  si_pkg::seg_pair_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/si_out_if.sv =====
// ----------------------------------------------------------------------------
// si_out_if: intersection result channel
// Valid/ready channel carrying one status and meeting point per beat.
// ----------------------------------------------------------------------------
interface si_out_if;
  logic          valid;
  logic          ready;
  si_pkg::meet_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/segment_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_intersection: intersection of two line segments
// Cross product front end, direction scaling, two pipelined dividers and a
// saturating output stage, all advancing together under one stall enable.
// ----------------------------------------------------------------------------
// path: front end, scale stage, divider and output register; the divider
// resolves one quotient bit per stage
// throughput: one beat per cycle; the whole pipe holds only when the output
// register is full and not taken
// reset: clears the valid bits only; data registers are not reset
module segment_intersection (
  input  logic clk_i,
  input  logic rst_ni,
  si_in_if.sink    in_i,
  si_out_if.source out_o
);

  localparam int CW = si_pkg::CW;
  localparam int MW = si_pkg::MW;
  localparam int VW = si_pkg::VW;
  localparam int DL = si_pkg::DL;
  localparam int LAT = DL + 5;   // front 3, scale 1, divider, output 1

  localparam logic signed [VW-1:0] MAXV = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] MINV = ~MAXV;

  typedef struct packed {
    si_pkg::coord_t sx;
    si_pkg::coord_t sy;
    logic           zero;
    logic           on_seg;
  } side_t;

  logic           en;
  logic [LAT-1:0] vld_q;
  si_pkg::front_t front;

  // scale stage
  logic signed [MW-1:0] mx_q, my_q;
  logic signed [si_pkg::NW-1:0] den_q;
  side_t side_d;
  side_t side_q [0:DL];

  logic [MW-1:0] qx, qy;
  logic          nx, ny;

  si_pkg::meet_t res_d, res_q;
  logic signed [VW-1:0] vx, vy;
  logic                 clip_x, clip_y;

  // the whole pipe moves unless a finished beat is waiting and not taken
  assign en          = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[LAT-1];
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  si_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .pair_i  (in_i.data),
    .front_o (front)
  );

  // direction times na numerator, one per axis
  always_comb begin
    side_d.sx     = front.sx;
    side_d.sy     = front.sy;
    side_d.zero   = (front.den == '0);
    side_d.on_seg = front.on_seg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q      <= front.ax * front.numa;
      my_q      <= front.ay * front.numa;
      den_q     <= front.den;
      side_q[0] <= side_d;
    end
  end

  // start point and status travel alongside the dividers
  for (genvar k = 0; k < DL; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  si_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mx_q),
    .den_i (den_q),
    .quo_o (qx),
    .neg_o (nx)
  );

  si_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (my_q),
    .den_i (den_q),
    .quo_o (qy),
    .neg_o (ny)
  );

  // start plus truncated quotient, then saturate to coordinate range
  always_comb begin
    vx = nx ? VW'(side_q[DL].sx) - VW'({2'b00, qx}) : VW'(side_q[DL].sx) + VW'({2'b00, qx});
    vy = ny ? VW'(side_q[DL].sy) - VW'({2'b00, qy}) : VW'(side_q[DL].sy) + VW'({2'b00, qy});
    clip_x = (vx < MINV) || (vx > MAXV);
    clip_y = (vy < MINV) || (vy > MAXV);

    res_d.meet_x = (vx < MINV) ? CW'(MINV) : ((vx > MAXV) ? CW'(MAXV) : CW'(vx));
    res_d.meet_y = (vy < MINV) ? CW'(MINV) : ((vy > MAXV) ? CW'(MAXV) : CW'(vy));
    res_d.clipped = clip_x || clip_y;
    res_d.status  = side_q[DL].on_seg ? si_pkg::ST_HIT : si_pkg::ST_OUTSIDE;

    // parallel or degenerate: everything zero
    if (side_q[DL].zero) begin
      res_d.meet_x  = '0;
      res_d.meet_y  = '0;
      res_d.clipped = 1'b0;
      res_d.status  = si_pkg::ST_PARALLEL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/si_front.sv =====
// ----------------------------------------------------------------------------
// si_front: cross product front end
// Three stages: differences, products, denominator and numerators with range test.
// ----------------------------------------------------------------------------
module si_front (
  input  logic              clk_i,
  input  logic              en_i,
  input  si_pkg::seg_pair_t pair_i,
  output si_pkg::front_t    front_o
);

  localparam int DW = si_pkg::DW;
  localparam int PW = si_pkg::PW;
  localparam int NW = si_pkg::NW;

  // stage 1
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  si_pkg::coord_t       sx1_q, sy1_q;
  // stage 2
  logic signed [PW-1:0] aybx_q, axby_q, bycx_q, bxcy_q, axcy_q, aycx_q;
  logic signed [DW-1:0] ax2_q, ay2_q;
  si_pkg::coord_t       sx2_q, sy2_q;
  // stage 3
  si_pkg::front_t       front_q;
  si_pkg::front_t       front_d;
  logic signed [NW-1:0] numb;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= DW'(pair_i.first_end_x) - DW'(pair_i.first_start_x);
      ay_q  <= DW'(pair_i.first_end_y) - DW'(pair_i.first_start_y);
      bx_q  <= DW'(pair_i.other_start_x) - DW'(pair_i.other_end_x);
      by_q  <= DW'(pair_i.other_start_y) - DW'(pair_i.other_end_y);
      cx_q  <= DW'(pair_i.first_start_x) - DW'(pair_i.other_start_x);
      cy_q  <= DW'(pair_i.first_start_y) - DW'(pair_i.other_start_y);
      sx1_q <= pair_i.first_start_x;
      sy1_q <= pair_i.first_start_y;

      aybx_q <= ay_q * bx_q;
      axby_q <= ax_q * by_q;
      bycx_q <= by_q * cx_q;
      bxcy_q <= bx_q * cy_q;
      axcy_q <= ax_q * cy_q;
      aycx_q <= ay_q * cx_q;
      ax2_q  <= ax_q;
      ay2_q  <= ay_q;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;

      front_q <= front_d;
    end
  end

  // a ratio lies in [0,1] when the numerator sits between zero and den
  function automatic logic in_unit(logic signed [NW-1:0] num, logic signed [NW-1:0] den);
    logic r;
    if (den[NW-1]) begin
      r = !(num > 0) && !(num < den);
    end else begin
      r = !num[NW-1] && !(num > den);
    end
    return r;
  endfunction

  always_comb begin
    front_d.den  = NW'(aybx_q) - NW'(axby_q);
    front_d.numa = NW'(bycx_q) - NW'(bxcy_q);
    numb         = NW'(axcy_q) - NW'(aycx_q);
    front_d.ax   = ax2_q;
    front_d.ay   = ay2_q;
    front_d.sx   = sx2_q;
    front_d.sy   = sy2_q;
    front_d.on_seg = in_unit(front_d.numa, front_d.den) && in_unit(numb, front_d.den);
  end

  assign front_o = front_q;

endmodule

// ===== rtl/si_div.sv =====
// ----------------------------------------------------------------------------
// si_div: pipelined signed divider
// Sign split stage then one restoring quotient bit per stage; magnitude out.
// ----------------------------------------------------------------------------
module si_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [si_pkg::MW-1:0] num_i,
  input  logic signed [si_pkg::NW-1:0] den_i,
  output logic        [si_pkg::MW-1:0] quo_o,
  output logic                         neg_o
);

  localparam int MW = si_pkg::MW;
  localparam int NW = si_pkg::NW;

  logic [MW-1:0] num_q [0:MW];
  logic [NW-1:0] den_q [0:MW];
  logic [NW-1:0] rem_q [0:MW];
  logic [MW-1:0] quo_q [0:MW];
  logic          neg_q [0:MW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num_i[MW-1] ? MW'(-num_i) : MW'(num_i);
      den_q[0] <= den_i[NW-1] ? NW'(-den_i) : NW'(den_i);
      neg_q[0] <= num_i[MW-1] ^ den_i[NW-1];
      rem_q[0] <= '0;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < MW; k++) begin : g_step
    logic [NW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_q[k], num_q[k][MW-1-k]};
      ge    = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? NW'(trial - {1'b0, den_q[k]}) : NW'(trial);
        quo_q[k+1] <= {quo_q[k][MW-2:0], ge};
        num_q[k+1] <= num_q[k];
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  assign quo_o = quo_q[MW];
  assign neg_o = neg_q[MW];

endmodule
